// ----- design/coi_pkg.sv -----
package coi_pkg;

  // Ring size default and arithmetic constants
  localparam int unsigned RingDepthDef = 16;
  localparam logic [63:0] NsPerSec     = 64'd1000000000;
  localparam logic [63:0] SMax         = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMin         = 64'h8000_0000_0000_0000;
  localparam logic [4:0]  DepthReset   = 5'd16;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_INTERP = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_LINE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_NONE   = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_RD, S_ADD_CHK, S_ADD_WR, S_SL_GO, S_SL_WT,
    S_BASE_GO, S_BASE_WT, S_DRM_GO, S_DRM_WT, S_L3_GO, S_L3_WT,
    S_MOD, S_SR_RD, S_SR_CHK, S_RDA_RD, S_RDA_CHK,
    S_E1_GO, S_E1_WT, S_E2_GO, S_E2_WT, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [63:0]        sample_timestamp;
    logic signed [63:0] sample_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] offset_result;
    logic [63:0]        entry_timestamp;
    logic signed [63:0] entry_offset;
    logic signed [63:0] latest_drift;
    logic signed [63:0] latest_base;
    logic signed [63:0] drift_mult;
    logic signed [63:0] base_ns;
  } out_t;

  typedef struct packed {
    logic [4:0] depth_in_use;
  } cfg_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  // Apply sign to a magnitude, clamping to the signed 64-bit range
  function automatic logic [63:0] signed_sat(input logic [63:0] m, input logic over,
                                             input logic neg);
    if (neg) begin
      signed_sat = (over || m > SMin) ? SMin : (64'd0 - m);
    end else begin
      signed_sat = (over || m > SMax) ? SMax : m;
    end
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add = a[63] ? SMin : SMax;
    end else begin
      sat_add = s;
    end
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) begin
      sat_sub = a[63] ? SMin : SMax;
    end else begin
      sat_sub = d;
    end
  endfunction

endpackage

// ----- design/coi_chan_if.sv -----
interface coi_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/clock_offset_interpolator.sv -----
// Clock offset interpolator: keeps a ring of (timestamp, offset) samples and a line fitted
// through the newest two. One beat is worked on at a time; a finished result sits in an output
// register so the next beat can be taken while it waits. Latency is set by the shared bit-serial
// 64x64 multiplier and 128/64 divider: an add that refits the line uses one divide and two
// multiplies, a line evaluation one multiply, and interpolate or find walk the ring from the
// newest entry back to the newest one older than the sample timestamp, then interpolate uses
// one divide and two multiplies. A rejected add or an empty ring skips the arithmetic units.
module clock_offset_interpolator #(
  parameter int unsigned RING_DEPTH = coi_pkg::RingDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  coi_chan_if.sink    in_i,
  coi_chan_if.source  out_o,
  coi_chan_if.sink    cfg_i
);
  import coi_pkg::*;

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned XW = (CW > 5) ? CW : 5;

  state_e state_q, state_d;

  // Control registers
  logic [4:0]    depth_cfg_q;
  logic [IW-1:0] ws_q, last_slot_q;
  logic          last_valid_q;
  logic [CW-1:0] fill_q;
  logic [63:0]   line_slope_q, line_base_q, drift_mult_q, base_ns_q;
  logic          out_v_q;

  // Working registers
  action_e       act_q;
  logic [63:0]   ts_q, so_q, ta_q, oa_q, tb_q, ob_q, anc_t_q, anc_o_q;
  logic [63:0]   slope_q, acc_q, res_q, et_q, eo_q;
  status_e       status_q;
  logic          mneg_q, sneg_q;
  logic [CW-1:0] r_q, i_q;
  logic [IW-1:0] p_q;
  out_t          out_q;

  // Ring memory
  logic [127:0]  ring_q [RING_DEPTH];
  logic [127:0]  rdata_q;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  logic [63:0]   rd_t, rd_o;

  // Arithmetic units
  logic          mul_start, mul_done, mul_neg;
  logic [63:0]   mul_a, mul_b, mres;
  logic [127:0]  mul_prod;
  logic          div_start, div_done, div_over;
  logic [63:0]   div_q, slope_w;

  // Derived values
  logic [XW-1:0] cfg_ext;
  logic [CW-1:0] depth_w, cnt_w, fill_new;
  logic [IW-1:0] wsn, ws_next, p_dec;
  logic [63:0]   doff, dt, dmag;
  logic          hit, none_w, accept, out_free;
  state_e        post_slope;

  assign rd_t = rdata_q[127:64];
  assign rd_o = rdata_q[63:0];

  // Effective depth and entries in use
  assign cfg_ext = XW'(depth_cfg_q);
  always_comb begin
    if (cfg_ext == '0) begin
      depth_w = CW'(1);
    end else if (cfg_ext > XW'(RING_DEPTH)) begin
      depth_w = CW'(RING_DEPTH);
    end else begin
      depth_w = CW'(cfg_ext);
    end
  end
  assign cnt_w    = (fill_q < depth_w) ? fill_q : depth_w;
  assign fill_new = (fill_q < depth_w) ? (fill_q + CW'(1)) : depth_w;
  assign wsn      = (CW'(ws_q) >= depth_w) ? '0 : ws_q;
  assign ws_next  = ((CW'(wsn) + CW'(1)) == depth_w) ? '0 : (wsn + IW'(1));
  assign p_dec    = (p_q == '0) ? IW'(cnt_w - CW'(1)) : (p_q - IW'(1));

  // Slope operands
  assign doff = sat_sub(ob_q, oa_q);
  assign dt   = tb_q - ta_q;
  assign dmag = mag(doff);

  assign mres    = signed_sat(mul_prod[103:40], |mul_prod[127:104], mneg_q);
  assign slope_w = signed_sat(div_q, div_over, sneg_q);

  assign hit      = ts_q > rd_t;
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_v_q || out_o.ready;
  assign none_w   = ((in_i.data.action == ACT_INTERP) && (cnt_w < CW'(2)))
                    || (cnt_w == '0);
  assign post_slope = (act_q == ACT_ADD) ? S_BASE_GO : S_E1_GO;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (action_e'(in_i.data.action))
            ACT_ADD: begin
              if (in_i.data.sample_timestamp == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = last_valid_q ? S_ADD_RD : S_ADD_WR;
              end
            end
            ACT_INTERP, ACT_FIND: state_d = none_w ? S_DONE : S_MOD;
            ACT_LINE: state_d = S_L3_GO;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ADD_RD:  state_d = S_ADD_CHK;
      S_ADD_CHK: state_d = (rd_t == ts_q) ? S_DONE : S_ADD_WR;
      S_ADD_WR:  state_d = (fill_new > CW'(1) && last_valid_q) ? S_SL_GO : S_DONE;
      S_SL_GO:   state_d = (dt == '0) ? post_slope : S_SL_WT;
      S_SL_WT:   state_d = div_done ? post_slope : S_SL_WT;
      S_BASE_GO: state_d = S_BASE_WT;
      S_BASE_WT: state_d = mul_done ? S_DRM_GO : S_BASE_WT;
      S_DRM_GO:  state_d = S_DRM_WT;
      S_DRM_WT:  state_d = mul_done ? S_DONE : S_DRM_WT;
      S_L3_GO:   state_d = S_L3_WT;
      S_L3_WT:   state_d = mul_done ? S_DONE : S_L3_WT;
      S_MOD:     state_d = (r_q >= cnt_w) ? S_MOD : S_SR_RD;
      S_SR_RD:   state_d = S_SR_CHK;
      S_SR_CHK: begin
        if (hit) begin
          if (act_q == ACT_FIND) begin
            state_d = S_DONE;
          end else begin
            state_d = (i_q == '0) ? S_RDA_RD : S_SL_GO;
          end
        end else begin
          state_d = ((i_q + CW'(1)) == cnt_w) ? S_DONE : S_SR_RD;
        end
      end
      S_RDA_RD:  state_d = S_RDA_CHK;
      S_RDA_CHK: state_d = S_SL_GO;
      S_E1_GO:   state_d = S_E1_WT;
      S_E1_WT:   state_d = mul_done ? S_E2_GO : S_E1_WT;
      S_E2_GO:   state_d = S_E2_WT;
      S_E2_WT:   state_d = mul_done ? S_DONE : S_E2_WT;
      S_DONE:    state_d = out_free ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control outputs: memory port, unit starts and operands
  always_comb begin
    raddr     = p_q;
    we        = 1'b0;
    waddr     = wsn;
    mul_start = 1'b0;
    mul_a     = mag(line_slope_q);
    mul_b     = ts_q;
    mul_neg   = line_slope_q[63];
    div_start = 1'b0;
    unique case (state_q)
      S_ADD_RD: raddr = last_slot_q;
      S_ADD_WR: we = 1'b1;
      S_SL_GO:  div_start = (dt != '0);
      S_BASE_GO, S_L3_GO: mul_start = 1'b1;
      S_DRM_GO: begin
        mul_start = 1'b1;
        mul_b     = NsPerSec;
        mul_neg   = !line_slope_q[63] && (line_slope_q != '0);
      end
      S_E1_GO: begin
        mul_start = 1'b1;
        mul_a     = mag(slope_q);
        mul_neg   = slope_q[63];
      end
      S_E2_GO: begin
        mul_start = 1'b1;
        mul_a     = mag(slope_q);
        mul_b     = anc_t_q;
        mul_neg   = slope_q[63];
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Ring memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_q[waddr] <= {ts_q, so_q};
    end
    rdata_q <= ring_q[raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      depth_cfg_q  <= DepthReset;
      ws_q         <= '0;
      last_slot_q  <= '0;
      last_valid_q <= 1'b0;
      fill_q       <= '0;
      line_slope_q <= '0;
      line_base_q  <= '0;
      drift_mult_q <= '0;
      base_ns_q    <= '0;
      out_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        depth_cfg_q <= cfg_i.data.depth_in_use;
      end
      if (state_q == S_ADD_WR) begin
        fill_q       <= fill_new;
        last_slot_q  <= wsn;
        last_valid_q <= 1'b1;
        ws_q         <= ws_next;
      end
      if (act_q == ACT_ADD && state_q == S_SL_GO && dt == '0) begin
        line_slope_q <= '0;
      end
      if (act_q == ACT_ADD && state_q == S_SL_WT && div_done) begin
        line_slope_q <= slope_w;
      end
      if (state_q == S_BASE_WT && mul_done) begin
        line_base_q <= sat_sub(so_q, mres);
      end
      if (state_q == S_DRM_WT && mul_done) begin
        drift_mult_q <= mres;
        base_ns_q    <= sat_sub(64'd0, line_base_q);
      end
      if (state_q == S_DONE && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_e'(in_i.data.action);
      ts_q  <= in_i.data.sample_timestamp;
      so_q  <= in_i.data.sample_offset;
      res_q <= '0;
      et_q  <= '0;
      eo_q  <= '0;
      r_q   <= CW'(ws_q);
      unique case (action_e'(in_i.data.action))
        ACT_ADD:  status_q <= (in_i.data.sample_timestamp == '0) ? ST_REJECT : ST_OK;
        ACT_LINE: status_q <= ST_OK;
        default:  status_q <= ST_NONE;
      endcase
    end
    unique case (state_q)
      S_ADD_CHK: begin
        if (rd_t == ts_q) begin
          status_q <= ST_REJECT;
        end
        ta_q <= rd_t;
        oa_q <= rd_o;
      end
      S_ADD_WR: begin
        tb_q <= ts_q;
        ob_q <= so_q;
        // Overwriting the previous slot makes it the new sample
        if (wsn == last_slot_q) begin
          ta_q <= ts_q;
          oa_q <= so_q;
        end
      end
      S_SL_GO: begin
        sneg_q <= doff[63] ^ dt[63];
        if (dt == '0) begin
          slope_q <= '0;
        end
      end
      S_SL_WT: begin
        if (div_done) begin
          slope_q <= slope_w;
        end
      end
      S_BASE_GO, S_DRM_GO, S_L3_GO, S_E1_GO, S_E2_GO: mneg_q <= mul_neg;
      S_L3_WT: begin
        if (mul_done) begin
          res_q <= sat_add(mres, line_base_q);
        end
      end
      S_MOD: begin
        if (r_q >= cnt_w) begin
          r_q <= r_q - cnt_w;
        end else begin
          p_q <= (r_q == '0) ? IW'(cnt_w - CW'(1)) : IW'(r_q - CW'(1));
          i_q <= '0;
        end
      end
      S_SR_CHK: begin
        if (hit) begin
          status_q <= ST_OK;
          et_q     <= (act_q == ACT_FIND) ? rd_t : 64'd0;
          eo_q     <= (act_q == ACT_FIND) ? rd_o : 64'd0;
          anc_t_q  <= rd_t;
          anc_o_q  <= rd_o;
          if (i_q == '0) begin
            tb_q <= rd_t;
            ob_q <= rd_o;
            p_q  <= p_dec;
          end else begin
            ta_q <= rd_t;
            oa_q <= rd_o;
          end
        end else begin
          tb_q <= rd_t;
          ob_q <= rd_o;
          i_q  <= i_q + CW'(1);
          p_q  <= p_dec;
        end
      end
      S_RDA_CHK: begin
        ta_q <= rd_t;
        oa_q <= rd_o;
      end
      S_E1_WT: begin
        if (mul_done) begin
          acc_q <= mres;
        end
      end
      S_E2_WT: begin
        if (mul_done) begin
          res_q <= sat_add(acc_q, sat_sub(anc_o_q, mres));
        end
      end
      default: begin
      end
    endcase
    if (state_q == S_DONE && out_free) begin
      out_q.status          <= status_q;
      out_q.offset_result   <= res_q;
      out_q.entry_timestamp <= et_q;
      out_q.entry_offset    <= eo_q;
      out_q.latest_drift    <= line_slope_q;
      out_q.latest_base     <= line_base_q;
      out_q.drift_mult      <= drift_mult_q;
      out_q.base_ns         <= base_ns_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  coi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  coi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .nhi_i   ({24'd0, dmag[63:24]}),
    .nlo_i   ({dmag[23:0], 40'd0}),
    .den_i   (mag(dt)),
    .done_o  (div_done),
    .quo_o   (div_q),
    .over_o  (div_over)
  );
endmodule

// ----- design/coi_mul.sv -----
module coi_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          done_o,
  output logic [127:0]  prod_o
);
  logic [63:0] a_q, hi_q, lo_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [64:0] sum;

  // One multiplier bit per cycle, LSB first
  assign sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? a_q : 64'd0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (run_q) begin
      hi_q <= sum[64:1];
      lo_q <= {sum[0], lo_q[63:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};
endmodule

// ----- design/coi_div.sv -----
module coi_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  nhi_i,
  input  logic [63:0]  nlo_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [63:0]  quo_o,
  output logic         over_o
);
  logic [63:0] rem_q, nq_q, den_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q, over_q;
  logic [63:0] shifted;
  logic        take;

  // Restoring step: one quotient bit per cycle
  assign shifted = {rem_q[62:0], nq_q[63]};
  assign take    = rem_q[63] || (shifted >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= nhi_i;
      nq_q   <= nlo_i;
      den_q  <= den_i;
      over_q <= (nhi_i >= den_i);
    end else if (run_q) begin
      rem_q <= take ? (shifted - den_q) : shifted;
      nq_q  <= {nq_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = over_q ? 64'd0 : nq_q;
  assign over_o = over_q;
endmodule

// ----- design/coi_checker.sv -----
module coi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input coi_pkg::out_t out_data_i
);
  import coi_pkg::*;

  // A waiting result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Rejected add carries no offset or entry
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ST_REJECT |->
      out_data_i.offset_result == 0 && out_data_i.entry_timestamp == 0
      && out_data_i.entry_offset == 0)
    else $error("rejected add returned data");

  // Negated base follows the published base
  a_base_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.latest_base == SMin) ? (out_data_i.base_ns == SMax)
                    : (out_data_i.base_ns == -out_data_i.latest_base))
    else $error("base_ns inconsistent with latest_base");

  // A flat line has no drift multiplier
  a_flat_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.latest_drift == 0 |-> out_data_i.drift_mult == 0)
    else $error("drift_mult nonzero for zero drift");
endmodule

bind clock_offset_interpolator coi_checker u_coi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
